// ===== design/fcw_pkg.sv =====
// Types and constants shared by the FAT12 cluster chain walker.
// No dependencies; compile first.
package fcw_pkg;

    // Item function codes; code 3 is unused and behaves as a load without a write.
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_OPEN = 2'd1;
    localparam logic [1:0] FUNC_ADV  = 2'd2;

    // Configuration register indexes.
    typedef enum logic {
        CFG_DATA_START = 1'b0,
        CFG_SPC        = 1'b1
    } t_cfg_idx;

    localparam logic [11:0] END_MARK   = 12'hFF8;
    localparam logic [11:0] OOR_ENTRY  = 12'hFFF;
    localparam logic [15:0] ENTRY_MASK = 16'h0FFF;

    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_AW    = 2;

    typedef struct packed {
        logic [31:0] lba;
        logic [11:0] cluster;
        logic        end_of_chain;
    } t_result;

endpackage

// ===== design/fcw_intf.sv =====
// Channel interfaces of the FAT12 cluster chain walker: item, result, configuration.
// Depends on nothing; compile after fcw_pkg.
interface fcw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [12:0] fat_address;
    logic [7:0]  fat_byte;
    logic [31:0] start_value;
    logic        root_mode;

    modport source (output valid, func, fat_address, fat_byte, start_value, root_mode,
                    input ready);
    modport sink   (input valid, func, fat_address, fat_byte, start_value, root_mode,
                    output ready);
endinterface

interface fcw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] lba;
    logic [11:0] cluster;
    logic        end_of_chain;

    modport source (output valid, lba, cluster, end_of_chain, input ready);
    modport sink   (input valid, lba, cluster, end_of_chain, output ready);
endinterface

interface fcw_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/fcw_fat_mem.sv =====
// FAT byte store split into even and odd banks so one read returns a 16-bit word.
// Depends on nothing beyond its ports.
module fcw_fat_mem #(
    parameter int unsigned FAT_BYTES = 8192
) (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic [12:0] i_wr_addr,
    input  logic [7:0]  i_wr_data,
    input  logic        i_rd_en,
    input  logic [12:0] i_rd_addr,
    output logic [7:0]  o_lo,
    output logic [7:0]  o_hi
);
    localparam int unsigned BANK_DEPTH = (FAT_BYTES + 1) / 2;
    localparam int unsigned AW         = $clog2(BANK_DEPTH);

    logic [7:0] r_even [BANK_DEPTH];
    logic [7:0] r_odd  [BANK_DEPTH];

    logic [AW-1:0] w_wr_bank;
    logic [AW-1:0] w_rd_odd;
    logic [AW-1:0] w_rd_even;
    logic          w_wr_ok;
    logic [7:0]    r_even_q;
    logic [7:0]    r_odd_q;
    logic          r_swap;

    assign w_wr_ok   = i_wr_en && ({1'b0, i_wr_addr} < 14'(FAT_BYTES));
    assign w_wr_bank = i_wr_addr[AW:1];
    assign w_rd_odd  = i_rd_addr[AW:1];
    // odd start address: the high byte sits in the next even slot
    assign w_rd_even = i_rd_addr[0] ? (i_rd_addr[AW:1] + AW'(1)) : i_rd_addr[AW:1];

    always_ff @(posedge i_clk) begin
        if (w_wr_ok && !i_wr_addr[0]) begin
            r_even[w_wr_bank] <= i_wr_data;
        end
        if (w_wr_ok && i_wr_addr[0]) begin
            r_odd[w_wr_bank] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_even_q <= r_even[w_rd_even];
            r_odd_q  <= r_odd[w_rd_odd];
            r_swap   <= i_rd_addr[0];
        end
    end

    assign o_lo = r_swap ? r_odd_q  : r_even_q;
    assign o_hi = r_swap ? r_even_q : r_odd_q;

endmodule

// ===== design/fcw_out_fifo.sv =====
// Result queue that parts the compute pipeline from the result channel.
// Depends on fcw_pkg and fcw_out_if.
module fcw_out_fifo
    import fcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_result           i_data,
    output logic [OUT_AW:0]   o_count,
    fcw_out_if.source         o_res
);
    t_result           r_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] r_head;
    logic [OUT_AW-1:0] r_tail;
    logic [OUT_AW:0]   r_count;
    logic [OUT_AW-1:0] n_head;
    logic [OUT_AW-1:0] n_tail;
    logic [OUT_AW:0]   n_count;
    logic              w_pop;

    assign w_pop = o_res.valid && o_res.ready;

    always_comb begin
        n_head  = w_pop  ? r_head + OUT_AW'(1) : r_head;
        n_tail  = i_push ? r_tail + OUT_AW'(1) : r_tail;
        n_count = r_count + (OUT_AW+1)'(i_push) - (OUT_AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_count            = r_count;
    assign o_res.valid        = (r_count != '0);
    assign o_res.lba          = r_mem[r_head].lba;
    assign o_res.cluster      = r_mem[r_head].cluster;
    assign o_res.end_of_chain = r_mem[r_head].end_of_chain;

endmodule

// ===== design/fat12_cluster_chain_walker.sv =====
// Top level of the FAT12 cluster chain walker: chain state, FAT lookup, LBA pipeline.
// Depends on fcw_pkg, fcw_intf, fcw_fat_mem and fcw_out_fifo.
//
// The block turns a FAT12 chain into the sector addresses of a file. Load items
// write the FAT one byte at a time into an on-chip store split into even and odd
// byte banks, so the 16-bit word holding any 12-bit entry comes back from one
// synchronous read. An open item sets the start cluster (or the start LBA in
// root mode) and clears the sector counter; each advance item moves one sector on
// and, at the end of a cluster, follows the FAT entry. Every item gives exactly
// one result. The block takes one item per cycle while the result queue has room;
// after an advance that crosses a cluster boundary, the next item waits for the
// FAT memory's read before the new cluster is known. Each result passes the FAT
// read, a 32x8 multiply of (cluster-2) by sectors_per_cluster, then the add with
// data_start_lba and the sector counter, before it enters the result queue.
// A four-entry result queue keeps items flowing while the result channel stalls.
// The FAT store has no reset and needs no clearing pass; reading a FAT byte that
// was never loaded gives an undefined next cluster. Configuration writes are
// taken in any cycle and must only be made while the block is idle.
module fat12_cluster_chain_walker
    import fcw_pkg::*;
#(
    parameter int unsigned FAT_BYTES = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcw_in_if.sink     i_item,
    fcw_cfg_if.sink    i_cfg,
    fcw_out_if.source  o_result
);
    // configuration
    logic [31:0] r_data_start;
    logic [7:0]  r_spc;

    // chain state
    logic [31:0] r_cluster;
    logic [7:0]  r_sector;
    logic        r_root;
    logic [31:0] n_cluster;
    logic [7:0]  n_sector;
    logic        n_root;

    // accept stage
    logic        w_accept;
    logic        w_space;
    logic        w_fat_wait;
    logic        a_load;
    logic        a_follow;
    logic        a_wr_en;
    logic [8:0]  a_sector_inc;
    logic [12:0] a_idx;
    logic        a_oor;

    // FAT lookup stage
    logic        r_s1_v;
    logic        r_s1_load;
    logic        r_s1_follow;
    logic        r_s1_oor;
    logic        r_s1_odd;
    logic [31:0] r_s1_cluster;
    logic [7:0]  r_s1_sector;
    logic        r_s1_root;
    logic [7:0]  w_lo;
    logic [7:0]  w_hi;
    logic [15:0] w_word;
    logic [11:0] w_entry;
    logic [31:0] w_s1_cur;
    logic [31:0] w_s1_off;
    logic [39:0] w_s1_prod;
    logic        w_s1_eoc;

    // LBA stage
    logic        r_s2_v;
    logic        r_s2_load;
    logic        r_s2_eoc;
    logic        r_s2_root;
    logic [31:0] r_s2_cur;
    logic [7:0]  r_s2_sector;
    logic [31:0] r_s2_prod;
    t_result     w_res;

    logic [OUT_AW:0] w_q_count;
    logic [OUT_AW:0] w_in_flight;

    // ---------------- configuration port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start <= '0;
            r_spc        <= 8'd1;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_DATA_START: r_data_start <= i_cfg.data;
                CFG_SPC:        r_spc        <= i_cfg.data[7:0];
            endcase
        end
    end

    // ---------------- accept stage ----------------
    // Count every item that will land in the result queue; hold input when full.
    assign w_in_flight = w_q_count + (OUT_AW+1)'(r_s1_v) + (OUT_AW+1)'(r_s2_v);
    assign w_space     = (w_in_flight < (OUT_AW+1)'(OUT_DEPTH));
    // The cluster is unknown until the FAT word returns: interlock input until then.
    assign w_fat_wait  = r_s1_v && r_s1_follow;
    assign i_item.ready = w_space && !w_fat_wait;
    assign w_accept    = i_item.valid && i_item.ready;

    // Entry byte offset is cluster*3/2; only clusters below the end mark are looked up.
    assign a_idx = {1'b0, r_cluster[11:0]} + {2'b00, r_cluster[11:1]};
    assign a_oor = ({1'b0, a_idx} + 14'd1) >= 14'(FAT_BYTES);
    assign a_sector_inc = {1'b0, r_sector} + 9'd1;

    always_comb begin
        n_cluster = r_cluster;
        n_sector  = r_sector;
        n_root    = r_root;
        a_load    = 1'b1;
        a_follow  = 1'b0;
        a_wr_en   = 1'b0;
        if (w_accept) begin
            case (i_item.func)
                FUNC_LOAD: begin
                    a_wr_en = 1'b1;
                end
                FUNC_OPEN: begin
                    a_load    = 1'b0;
                    n_cluster = i_item.start_value;
                    n_sector  = '0;
                    n_root    = i_item.root_mode;
                end
                FUNC_ADV: begin
                    a_load = 1'b0;
                    if (r_root) begin
                        n_cluster = r_cluster + 32'd1;
                    end else if (r_cluster < {20'd0, END_MARK}) begin
                        if (a_sector_inc >= {1'b0, r_spc}) begin
                            // end of cluster: wrap the counter, follow the FAT
                            n_sector = '0;
                            a_follow = 1'b1;
                        end else begin
                            n_sector = a_sector_inc[7:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster <= '0;
            r_sector  <= '0;
            r_root    <= 1'b0;
        end else begin
            // a pending FAT follow blocks input, so it cannot collide with n_cluster
            r_cluster <= w_fat_wait ? w_s1_cur : n_cluster;
            r_sector  <= n_sector;
            r_root    <= n_root;
        end
    end

    fcw_fat_mem #(
        .FAT_BYTES (FAT_BYTES)
    ) u_fat_mem (
        .i_clk     (i_clk),
        .i_wr_en   (a_wr_en),
        .i_wr_addr (i_item.fat_address),
        .i_wr_data (i_item.fat_byte),
        .i_rd_en   (a_follow),
        .i_rd_addr (a_idx),
        .o_lo      (w_lo),
        .o_hi      (w_hi)
    );

    // ---------------- FAT lookup stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s1_follow <= 1'b0;
        end else begin
            r_s1_v      <= w_accept;
            r_s1_follow <= a_follow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_load    <= a_load;
        r_s1_oor     <= a_oor;
        r_s1_odd     <= r_cluster[0];
        r_s1_cluster <= n_cluster;
        r_s1_sector  <= n_sector;
        r_s1_root    <= n_root;
    end

    assign w_word  = {w_hi, w_lo};
    // even cluster takes the low 12 bits, odd cluster the top 12
    assign w_entry = r_s1_odd ? w_word[15:4] : w_word[11:0] & ENTRY_MASK[11:0];
    assign w_s1_cur = !r_s1_follow ? r_s1_cluster :
                      r_s1_oor     ? {20'd0, OOR_ENTRY} : {20'd0, w_entry};
    assign w_s1_eoc  = !r_s1_root && (w_s1_cur >= {20'd0, END_MARK});
    assign w_s1_off  = w_s1_cur - 32'd2;
    assign w_s1_prod = {8'd0, w_s1_off} * {32'd0, r_spc};

    // ---------------- LBA stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_load   <= r_s1_load;
        r_s2_eoc    <= w_s1_eoc;
        r_s2_root   <= r_s1_root;
        r_s2_cur    <= w_s1_cur;
        r_s2_sector <= r_s1_sector;
        r_s2_prod   <= w_s1_prod[31:0];
    end

    always_comb begin
        if (r_s2_root) begin
            w_res.lba = r_s2_load ? 32'd0 : r_s2_cur;
        end else if (r_s2_load || r_s2_eoc) begin
            w_res.lba = 32'd0;
        end else begin
            w_res.lba = r_data_start + r_s2_prod + {24'd0, r_s2_sector};
        end
        w_res.cluster      = r_s2_root ? 12'd0 : r_s2_cur[11:0];
        w_res.end_of_chain = r_s2_eoc;
    end

    fcw_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_v),
        .i_data  (w_res),
        .o_count (w_q_count),
        .o_res   (o_result)
    );

endmodule

// ===== design/fcw_checker.sv =====
// Port-level checks for the FAT12 cluster chain walker, bound to the top level.
// Depends on fat12_cluster_chain_walker's ports only.
module fcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_lba,
    input logic [11:0] i_out_cluster,
    input logic        i_out_eoc
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_lba: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_lba))
        else $error("result lba changed while stalled");

    a_hold_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_cluster) && $stable(i_out_eoc))
        else $error("result cluster or end flag changed while stalled");

    a_eoc_lba: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_eoc |-> i_out_lba == 32'd0)
        else $error("end of chain with a nonzero sector address");

endmodule

bind fat12_cluster_chain_walker fcw_checker u_fcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_lba     (o_result.lba),
    .i_out_cluster (o_result.cluster),
    .i_out_eoc     (o_result.end_of_chain)
);
